### rtl/core/bcls_pkg.sv
`default_nettype none

package bcls_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int SKIP_BITS      = 20;
    localparam int MAX_BITS       = 17;

    localparam logic [SKIP_BITS-1:0] SKIP_MAX = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PARAM_SLOTS   = 2'd0,
        CFG_STATIC_METHOD = 2'd1,
        CFG_DECLARED_MAX  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_OPCODE     = 3'd0,
        PH_SKIP       = 3'd1,
        PH_INDEX      = 3'd2,
        PH_WIDE_OP    = 3'd3,
        PH_WIDE_IDX   = 3'd4,
        PH_TABLE_HDR  = 3'd5,
        PH_LOOKUP_HDR = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic       empty_code;
    } in_item_t;

    typedef struct packed {
        logic [15:0] req_slots;
        logic [15:0] final_slots;
        logic        corrected;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  arg_slots;
        logic        static_method;
        logic [15:0] declared_slots;
    } cfg_t;

    // opcodes
    localparam logic [7:0] OP_BIPUSH          = 8'h10;
    localparam logic [7:0] OP_SIPUSH          = 8'h11;
    localparam logic [7:0] OP_LDC             = 8'h12;
    localparam logic [7:0] OP_LDC_W           = 8'h13;
    localparam logic [7:0] OP_LDC2_W          = 8'h14;
    localparam logic [7:0] OP_ILOAD           = 8'h15;
    localparam logic [7:0] OP_ALOAD           = 8'h19;
    localparam logic [7:0] OP_ILOAD_0         = 8'h1a;
    localparam logic [7:0] OP_ALOAD_3         = 8'h2d;
    localparam logic [7:0] OP_ISTORE          = 8'h36;
    localparam logic [7:0] OP_ASTORE          = 8'h3a;
    localparam logic [7:0] OP_ISTORE_0        = 8'h3b;
    localparam logic [7:0] OP_ASTORE_3        = 8'h4e;
    localparam logic [7:0] OP_IINC            = 8'h84;
    localparam logic [7:0] OP_IFEQ            = 8'h99;
    localparam logic [7:0] OP_JSR             = 8'ha8;
    localparam logic [7:0] OP_RET             = 8'ha9;
    localparam logic [7:0] OP_TABLESWITCH     = 8'haa;
    localparam logic [7:0] OP_LOOKUPSWITCH    = 8'hab;
    localparam logic [7:0] OP_GETSTATIC       = 8'hb2;
    localparam logic [7:0] OP_INVOKESTATIC    = 8'hb8;
    localparam logic [7:0] OP_INVOKEINTERFACE = 8'hb9;
    localparam logic [7:0] OP_INVOKEDYNAMIC   = 8'hba;
    localparam logic [7:0] OP_NEW             = 8'hbb;
    localparam logic [7:0] OP_NEWARRAY        = 8'hbc;
    localparam logic [7:0] OP_ANEWARRAY       = 8'hbd;
    localparam logic [7:0] OP_CHECKCAST       = 8'hc0;
    localparam logic [7:0] OP_INSTANCEOF      = 8'hc1;
    localparam logic [7:0] OP_WIDE            = 8'hc4;
    localparam logic [7:0] OP_MULTIANEWARRAY  = 8'hc5;
    localparam logic [7:0] OP_IFNULL          = 8'hc6;
    localparam logic [7:0] OP_IFNONNULL       = 8'hc7;
    localparam logic [7:0] OP_GOTO_W          = 8'hc8;
    localparam logic [7:0] OP_JSR_W           = 8'hc9;

    // operand bytes after the opcode for fixed-length instructions
    function automatic logic [2:0] operand_bytes(input logic [7:0] op);
        logic [2:0] n;
        n = 3'd0;
        if (op == OP_BIPUSH || op == OP_LDC || op == OP_NEWARRAY)
            n = 3'd1;
        else if (op == OP_SIPUSH || op == OP_LDC_W || op == OP_LDC2_W)
            n = 3'd2;
        else if (op >= OP_IFEQ && op <= OP_JSR)
            n = 3'd2;
        else if ((op >= OP_GETSTATIC && op <= OP_INVOKESTATIC) || op == OP_NEW
                 || op == OP_ANEWARRAY)
            n = 3'd2;
        else if (op == OP_CHECKCAST || op == OP_INSTANCEOF || op == OP_IFNULL
                 || op == OP_IFNONNULL)
            n = 3'd2;
        else if (op == OP_INVOKEINTERFACE || op == OP_INVOKEDYNAMIC || op == OP_GOTO_W
                 || op == OP_JSR_W)
            n = 3'd4;
        else if (op == OP_MULTIANEWARRAY)
            n = 3'd3;
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bytecode_local_slot_scanner.sv
`default_nettype none

// Scans one method's bytecode, one byte per transfer, and reports the local
// slots it needs. Throughput is one byte per clock unless the input stalls; a
// byte passes an input register, the scan state update and the result register,
// so a method's result shows on result_valid once its last byte (or empty_code
// item) reaches the result register. The input stalls only while a finished
// method waits for a result register held by a stalled result. The per-byte
// scan state update is the single combinational step that sets the clock rate.
// No clearing pass after reset. Registers (parameter slots, static flag,
// declared slot limit) are written through cfg_* and keep their values between
// methods; the user must write them only while idle, not enforced by the block.
module bytecode_local_slot_scanner #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              code_valid,
    output logic                                   code_stall,
    input  wire bcls_pkg::in_item_t                code_item,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output bcls_pkg::out_item_t                    result_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bcls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [15:0]                       cfg_data
);

    import bcls_pkg::*;

    cfg_t                cfg_reg, cfg_next;
    logic                s1_valid_reg, s1_valid_next;
    in_item_t            s1_item_reg;
    logic                accept;
    logic                advance;
    logic                s1_ends;
    logic                out_free;
    logic [MAX_BITS-1:0] seen_max;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PARAM_SLOTS:   cfg_next.arg_slots      = cfg_data[7:0];
                CFG_STATIC_METHOD: cfg_next.static_method  = cfg_data[0];
                CFG_DECLARED_MAX:  cfg_next.declared_slots = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // input stage moves on unless its result cannot get into the output register
    assign s1_ends       = s1_item_reg.last_byte || s1_item_reg.empty_code;
    assign advance       = s1_valid_reg && (!s1_ends || out_free);
    assign code_stall    = s1_valid_reg && !advance;
    assign accept        = code_valid && !code_stall;
    assign s1_valid_next = accept ? 1'b1 : (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= code_item;
    end

    bcls_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (s1_item_reg),
        .seen_max (seen_max)
    );

    bcls_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && s1_ends),
        .seen_max     (seen_max),
        .cfg          (cfg_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_item  (result_item),
        .free         (out_free)
    );

`ifndef SYNTHESIS
    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        code_stall |=> (s1_valid_reg && s1_item_reg == $past(s1_item_reg)))
        else $error("input stage lost a stalled byte");

    a_stall_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        code_stall |-> (s1_ends && result_valid && result_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

### rtl/core/bcls_scan.sv
`default_nettype none

module bcls_scan #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire bcls_pkg::in_item_t        item,
    output logic [bcls_pkg::MAX_BITS-1:0]  seen_max
);

    import bcls_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [SKIP_BITS-1:0]     skip_reg, skip_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [31:0]              hdr_reg, hdr_next;
    logic [31:0]              low_reg, low_next;
    logic [15:0]              idx_reg, idx_next;
    logic [MAX_BITS-1:0]      max_reg, max_next;

    logic [7:0]           op;
    logic [7:0]           load_off;
    logic [7:0]           store_off;
    logic [SKIP_BITS-1:0] skip_dec;
    logic [15:0]          idx_shift;
    logic [31:0]          hdr_shift;
    logic [1:0]           pad;
    logic [2:0]           extra;
    logic                 is_load;
    logic                 is_store;
    logic                 note_en;
    logic [15:0]          note_idx;
    logic [MAX_BITS-1:0]  note_val;
    logic [MAX_BITS-1:0]  max_after;
    logic signed [33:0]   tbl_count;
    logic [SKIP_BITS-1:0] tbl_skip;
    logic [SKIP_BITS-1:0] lkp_skip;

    assign op        = item.code_byte;
    assign load_off  = op - OP_ILOAD_0;
    assign store_off = op - OP_ISTORE_0;
    assign is_load   = (op >= OP_ILOAD_0) && (op <= OP_ALOAD_3);
    assign is_store  = (op >= OP_ISTORE_0) && (op <= OP_ASTORE_3);
    assign skip_dec  = (skip_reg != '0) ? skip_reg - SKIP_BITS'(1) : skip_reg;
    assign idx_shift = {idx_reg[7:0], op};
    assign hdr_shift = {hdr_reg[23:0], op};
    // padding up to the next four-byte boundary after the switch opcode
    assign pad       = ~pos_reg[1:0];
    assign extra     = operand_bytes(op);

    // table entries: high - low + 1, four bytes each
    assign tbl_count = $signed({{2{hdr_shift[31]}}, hdr_shift})
                     - $signed({{2{low_reg[31]}}, low_reg}) + 34'sd1;

    always_comb
    begin
        if (tbl_count[33] || tbl_count == 34'sd0)
            tbl_skip = '0;
        else if (tbl_count[33:18] != '0)
            tbl_skip = SKIP_MAX;
        else
            tbl_skip = {tbl_count[17:0], 2'b00};
    end

    // lookup pairs, eight bytes each
    always_comb
    begin
        if (hdr_shift[31] || hdr_shift == '0)
            lkp_skip = '0;
        else if (hdr_shift[30:17] != '0)
            lkp_skip = SKIP_MAX;
        else
            lkp_skip = {hdr_shift[16:0], 3'b000};
    end

    // slot named by this byte
    always_comb
    begin
        note_en  = 1'b0;
        note_idx = '0;
        unique case (phase_reg)
            PH_OPCODE:
            begin
                if (is_load)
                begin
                    note_en  = 1'b1;
                    note_idx = {14'd0, load_off[1:0]};
                end
                else if (is_store)
                begin
                    note_en  = 1'b1;
                    note_idx = {14'd0, store_off[1:0]};
                end
            end
            PH_INDEX:
            begin
                note_en  = 1'b1;
                note_idx = {8'd0, op};
            end
            PH_WIDE_IDX:
            begin
                if (skip_dec == '0)
                begin
                    note_en  = 1'b1;
                    note_idx = idx_shift;
                end
            end
            default:
            begin
                note_en  = 1'b0;
                note_idx = '0;
            end
        endcase
    end

    assign note_val  = {1'b0, note_idx} + MAX_BITS'(1);
    assign max_after = (note_en && note_val > max_reg) ? note_val : max_reg;
    assign seen_max  = item.empty_code ? max_reg : max_after;

    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        low_next   = low_reg;
        idx_next   = idx_reg;
        max_next   = max_reg;
        if (step && !item.empty_code)
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
            max_next = max_after;
            unique case (phase_reg)
                PH_OPCODE:
                begin
                    priority if (is_load || is_store)
                    begin
                        phase_next = PH_OPCODE;
                    end
                    else if ((op >= OP_ILOAD && op <= OP_ALOAD)
                             || (op >= OP_ISTORE && op <= OP_ASTORE) || op == OP_RET)
                    begin
                        phase_next = PH_INDEX;
                        skip_next  = '0;
                    end
                    else if (op == OP_IINC)
                    begin
                        phase_next = PH_INDEX;
                        skip_next  = SKIP_BITS'(1);
                    end
                    else if (op == OP_WIDE)
                    begin
                        phase_next = PH_WIDE_OP;
                    end
                    else if (op == OP_TABLESWITCH)
                    begin
                        phase_next = PH_TABLE_HDR;
                        skip_next  = SKIP_BITS'(pad) + SKIP_BITS'(12);
                        hdr_next   = '0;
                    end
                    else if (op == OP_LOOKUPSWITCH)
                    begin
                        phase_next = PH_LOOKUP_HDR;
                        skip_next  = SKIP_BITS'(pad) + SKIP_BITS'(8);
                        hdr_next   = '0;
                    end
                    else if (extra != '0)
                    begin
                        phase_next = PH_SKIP;
                        skip_next  = SKIP_BITS'(extra);
                    end
                    else
                    begin
                        phase_next = PH_OPCODE;
                    end
                end
                PH_INDEX:
                begin
                    phase_next = (skip_reg != '0) ? PH_SKIP : PH_OPCODE;
                end
                PH_WIDE_OP:
                begin
                    hdr_next   = {24'd0, op};
                    idx_next   = '0;
                    skip_next  = SKIP_BITS'(2);
                    phase_next = PH_WIDE_IDX;
                end
                PH_WIDE_IDX:
                begin
                    idx_next  = idx_shift;
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        // wide iinc still has its two constant bytes
                        if (hdr_reg == {24'd0, OP_IINC})
                        begin
                            phase_next = PH_SKIP;
                            skip_next  = SKIP_BITS'(2);
                        end
                        else
                        begin
                            phase_next = PH_OPCODE;
                        end
                    end
                end
                PH_TABLE_HDR:
                begin
                    hdr_next  = hdr_shift;
                    skip_next = skip_dec;
                    if (skip_dec == SKIP_BITS'(4))
                        low_next = hdr_shift;
                    if (skip_dec == '0)
                    begin
                        skip_next  = tbl_skip;
                        phase_next = (tbl_skip != '0) ? PH_SKIP : PH_OPCODE;
                    end
                end
                PH_LOOKUP_HDR:
                begin
                    hdr_next  = hdr_shift;
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        skip_next  = lkp_skip;
                        phase_next = (lkp_skip != '0) ? PH_SKIP : PH_OPCODE;
                    end
                end
                default:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        phase_next = PH_OPCODE;
                end
            endcase
        end
        // end of method: back to a clean scan
        if (step && (item.empty_code || item.last_byte))
        begin
            phase_next = PH_OPCODE;
            skip_next  = '0;
            pos_next   = '0;
            hdr_next   = '0;
            low_next   = '0;
            idx_next   = '0;
            max_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPCODE;
            skip_reg  <= '0;
            pos_reg   <= '0;
            hdr_reg   <= '0;
            low_reg   <= '0;
            idx_reg   <= '0;
            max_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            low_reg   <= low_next;
            idx_reg   <= idx_next;
            max_reg   <= max_next;
        end
    end

`ifndef SYNTHESIS
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != '0)
        else $error("skip phase with nothing left to skip");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.last_byte || item.empty_code))
        |=> (phase_reg == PH_OPCODE && max_reg == '0 && pos_reg == '0))
        else $error("scan state not cleared after end of method");

    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !item.last_byte && !item.empty_code) |=> max_reg >= $past(max_reg))
        else $error("highest slot went down mid-method");
`endif

endmodule

`default_nettype wire

### rtl/core/bcls_result.sv
`default_nettype none

module bcls_result (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire logic [bcls_pkg::MAX_BITS-1:0] seen_max,
    input  wire bcls_pkg::cfg_t           cfg,
    input  wire logic                     result_stall,
    output logic                          result_valid,
    output bcls_pkg::out_item_t           result_item,
    output logic                          free
);

    import bcls_pkg::*;

    logic                valid_reg, valid_next;
    out_item_t           item_reg;
    logic [8:0]          base_slots;
    logic [MAX_BITS-1:0] need_wide;
    logic [15:0]         need;
    out_item_t           item_next;

    // "this" takes one slot unless the method is static
    assign base_slots = {1'b0, cfg.arg_slots} + {8'd0, ~cfg.static_method};
    assign need_wide  = (seen_max > MAX_BITS'(base_slots)) ? seen_max : MAX_BITS'(base_slots);
    assign need       = need_wide[MAX_BITS-1] ? 16'hffff : need_wide[15:0];

    always_comb
    begin
        item_next.req_slots   = need;
        item_next.corrected   = need > cfg.declared_slots;
        item_next.final_slots = item_next.corrected ? need : cfg.declared_slots;
    end

    assign free       = !valid_reg || !result_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

`ifndef SYNTHESIS
    a_final_covers_need: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.final_slots >= result_item.req_slots
                          && (result_item.corrected
                              || result_item.final_slots >= result_item.req_slots)))
        else $error("final slot count below needed slots");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_stall) |-> !load)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

### tb/bytecode_local_slot_scanner_tb.sv
`timescale 1ns / 100ps

module bytecode_local_slot_scanner_tb;

    import bcls_pkg::*;

    // index past the end of the register list, must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      code_valid;
    logic                      code_stall;
    in_item_t                  code_item;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    out_item_t                 result_item;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [15:0]               cfg_data;

    // scan state mirror
    phase_t      scan_ph;
    logic [19:0] skip_left;
    logic [15:0] byte_pos;
    logic [31:0] hdr_word;
    logic [31:0] low_word;
    logic [15:0] wide_index;
    logic [16:0] slot_top;
    logic [7:0]  reg_params;
    logic        reg_static;
    logic [15:0] reg_declared;

    out_item_t   expected_locals_q[$];
    logic [7:0]  code_buf[$];
    int          errors = 0;
    int          sent_items = 0;
    bit          jitter_on = 1'b1;

    bytecode_local_slot_scanner u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .code_item    (code_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        result_stall <= jitter_on && ($urandom_range(99) < 27);
    end

    function automatic int operand_count(input logic [7:0] op);
        int n;
        case (op)
            OP_BIPUSH, OP_LDC, OP_NEWARRAY: n = 1;
            OP_MULTIANEWARRAY: n = 3;
            OP_INVOKEINTERFACE, OP_INVOKEDYNAMIC, OP_GOTO_W, OP_JSR_W: n = 4;
            OP_SIPUSH, OP_LDC_W, OP_LDC2_W, OP_NEW, OP_ANEWARRAY,
            OP_CHECKCAST, OP_INSTANCEOF, OP_IFNULL, OP_IFNONNULL: n = 2;
            default:
                n = ((op >= OP_IFEQ && op <= OP_JSR)
                     || (op >= OP_GETSTATIC && op <= OP_INVOKESTATIC)) ? 2 : 0;
        endcase
        return n;
    endfunction

    // load, store or ret with a one-byte slot operand
    function automatic bit is_indexed(input logic [7:0] op);
        return (op >= OP_ILOAD && op <= OP_ALOAD) || (op >= OP_ISTORE && op <= OP_ASTORE)
               || op == OP_RET;
    endfunction

    function automatic logic [19:0] table_bytes(input longint count, input int unit);
        longint total;
        if (count <= 0)
            return '0;
        total = count * unit;
        return (total > longint'(SKIP_MAX)) ? SKIP_MAX : total[19:0];
    endfunction

    task automatic reset_scan();
        scan_ph    = PH_OPCODE;
        skip_left  = '0;
        byte_pos   = '0;
        hdr_word   = '0;
        low_word   = '0;
        wide_index = '0;
        slot_top   = '0;
    endtask

    task automatic note_slot(input logic [15:0] idx);
        logic [16:0] v;
        v = {1'b0, idx} + 17'd1;
        if (v > slot_top)
            slot_top = v;
    endtask

    task automatic close_method();
        logic [16:0] need;
        out_item_t   r;
        need = {9'd0, reg_params} + (reg_static ? 17'd0 : 17'd1);
        if (slot_top > need)
            need = slot_top;
        if (need > 17'h0ffff)
            need = 17'h0ffff;
        r.req_slots   = need[15:0];
        r.corrected   = need[15:0] > reg_declared;
        r.final_slots = r.corrected ? need[15:0] : reg_declared;
        expected_locals_q.push_back(r);
        reset_scan();
    endtask

    task automatic track_scan(input in_item_t it);
        logic [7:0] b;
        logic [7:0] diff;
        logic [1:0] pad;
        int         n;
        b = it.code_byte;
        if (it.empty_code)
        begin
            close_method();
            return;
        end
        case (scan_ph)
            PH_OPCODE:
            begin
                // padding up to the next multiple of four after the opcode
                pad = 2'd3 - byte_pos[1:0];
                if (b >= OP_ILOAD_0 && b <= OP_ALOAD_3)
                begin
                    diff = b - OP_ILOAD_0;
                    note_slot({14'd0, diff[1:0]});
                end
                else if (b >= OP_ISTORE_0 && b <= OP_ASTORE_3)
                begin
                    diff = b - OP_ISTORE_0;
                    note_slot({14'd0, diff[1:0]});
                end
                else if (is_indexed(b))
                begin
                    scan_ph   = PH_INDEX;
                    skip_left = '0;
                end
                else if (b == OP_IINC)
                begin
                    scan_ph   = PH_INDEX;
                    skip_left = 20'd1;
                end
                else if (b == OP_WIDE)
                    scan_ph = PH_WIDE_OP;
                else if (b == OP_TABLESWITCH)
                begin
                    scan_ph   = PH_TABLE_HDR;
                    skip_left = 20'(pad) + 20'd12;
                    hdr_word  = '0;
                end
                else if (b == OP_LOOKUPSWITCH)
                begin
                    scan_ph   = PH_LOOKUP_HDR;
                    skip_left = 20'(pad) + 20'd8;
                    hdr_word  = '0;
                end
                else
                begin
                    n = operand_count(b);
                    if (n > 0)
                    begin
                        scan_ph   = PH_SKIP;
                        skip_left = 20'(n);
                    end
                end
            end
            PH_INDEX:
            begin
                note_slot({8'd0, b});
                scan_ph = (skip_left != 0) ? PH_SKIP : PH_OPCODE;
            end
            PH_WIDE_OP:
            begin
                hdr_word   = {24'd0, b};
                wide_index = '0;
                skip_left  = 20'd2;
                scan_ph    = PH_WIDE_IDX;
            end
            PH_WIDE_IDX:
            begin
                wide_index = {wide_index[7:0], b};
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0)
                begin
                    note_slot(wide_index);
                    if (hdr_word == {24'd0, OP_IINC})
                    begin
                        scan_ph   = PH_SKIP;
                        skip_left = 20'd2;
                    end
                    else
                        scan_ph = PH_OPCODE;
                end
            end
            PH_TABLE_HDR:
            begin
                hdr_word = {hdr_word[23:0], b};
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 20'd4)
                    low_word = hdr_word;
                if (skip_left == 0)
                begin
                    skip_left = table_bytes(longint'($signed(hdr_word))
                                            - longint'($signed(low_word)) + 1, 4);
                    scan_ph = (skip_left != 0) ? PH_SKIP : PH_OPCODE;
                end
            end
            PH_LOOKUP_HDR:
            begin
                hdr_word = {hdr_word[23:0], b};
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0)
                begin
                    skip_left = table_bytes(longint'($signed(hdr_word)), 8);
                    scan_ph = (skip_left != 0) ? PH_SKIP : PH_OPCODE;
                end
            end
            default:
            begin
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0)
                    scan_ph = PH_OPCODE;
            end
        endcase
        byte_pos++;
        if (it.last_byte)
            close_method();
    endtask

    // holds the byte until the transfer, then updates the mirror
    task automatic push_byte(input in_item_t it);
        while (jitter_on && $urandom_range(99) < 27)
        begin
            code_valid <= 1'b0;
            @(posedge clk);
        end
        code_valid <= 1'b1;
        code_item  <= it;
        @(posedge clk);
        while (code_stall)
            @(posedge clk);
        track_scan(it);
        sent_items++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PARAM_SLOTS:   reg_params   = data[7:0];
            CFG_STATIC_METHOD: reg_static   = data[0];
            CFG_DECLARED_MAX:  reg_declared = data;
            default: ;
        endcase
    endtask

    task automatic settle();
        code_valid <= 1'b0;
        while (expected_locals_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sends the first keep bytes of code_buf, closed by last_byte or by an empty item
    task automatic send_buffer(input int keep, input bit by_empty);
        in_item_t it;
        for (int i = 0; i < keep; i++)
        begin
            it.code_byte  = code_buf[i];
            it.last_byte  = !by_empty && (i == keep - 1);
            it.empty_code = 1'b0;
            push_byte(it);
        end
        if (by_empty)
        begin
            it.code_byte  = 8'($urandom);
            it.last_byte  = 1'($urandom);
            it.empty_code = 1'b1;
            push_byte(it);
        end
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            code_buf.push_back(w[8*i +: 8]);
    endtask

    function automatic logic [7:0] slot_byte();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    endfunction

    task automatic add_instruction();
        logic [7:0]  op;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] pairs;
        int          sel;
        int          n;
        case ($urandom_range(0, 11))
            0: op = OP_ILOAD_0 + 8'($urandom_range(0, 19));
            1: op = OP_ISTORE_0 + 8'($urandom_range(0, 19));
            2: op = $urandom_range(0, 1) ? OP_ILOAD + 8'($urandom_range(0, 4))
                                         : OP_ISTORE + 8'($urandom_range(0, 4));
            3: op = OP_RET;
            4: op = OP_IINC;
            5, 6: op = OP_WIDE;
            7: op = $urandom_range(0, 1) ? OP_TABLESWITCH : OP_LOOKUPSWITCH;
            default: op = 8'($urandom);
        endcase
        code_buf.push_back(op);
        if (is_indexed(op))
            code_buf.push_back(slot_byte());
        else if (op == OP_IINC)
        begin
            code_buf.push_back(slot_byte());
            code_buf.push_back(8'($urandom));
        end
        else if (op == OP_WIDE)
        begin
            sel = $urandom_range(0, 15);
            if (sel < 5)
                op = OP_ILOAD + 8'(sel);
            else if (sel < 10)
                op = OP_ISTORE + 8'(sel - 5);
            else if (sel == 10)
                op = OP_IINC;
            else if (sel == 11)
                op = OP_RET;
            else
                op = 8'($urandom);
            code_buf.push_back(op);
            code_buf.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd0);
            code_buf.push_back(8'($urandom));
            if (op == OP_IINC)
            begin
                code_buf.push_back(8'($urandom));
                code_buf.push_back(8'($urandom));
            end
        end
        else if (op == OP_TABLESWITCH || op == OP_LOOKUPSWITCH)
        begin
            repeat ((4 - code_buf.size() % 4) % 4) code_buf.push_back(8'($urandom));
            put_word($urandom);
            if (op == OP_TABLESWITCH)
            begin
                lo = 32'($urandom_range(0, 20)) - 32'd10;
                hi = lo + 32'($urandom_range(0, 5)) - 32'd2;
                // full 32-bit range: table length saturates, method ends inside it
                if ($urandom_range(0, 15) == 0)
                begin
                    lo = 32'h8000_0000;
                    hi = 32'h7fff_ffff;
                end
                put_word(lo);
                put_word(hi);
                n = ($signed(hi - lo) >= 0 && $signed(hi - lo) < 8)
                    ? int'($signed(hi - lo)) + 1 : 0;
                repeat (4 * n) code_buf.push_back(8'($urandom));
            end
            else
            begin
                pairs = 32'($urandom_range(0, 4)) - 32'd1;
                if ($urandom_range(0, 15) == 0)
                    pairs = {1'b1, 31'($urandom)};
                put_word(pairs);
                n = $signed(pairs) > 0 ? int'(pairs) : 0;
                repeat (8 * n) code_buf.push_back(8'($urandom));
            end
        end
        else
            repeat (operand_count(op)) code_buf.push_back(8'($urandom));
    endtask

    task automatic random_method();
        int count;
        int mode;
        int keep;
        code_buf.delete();
        count = $urandom_range(1, 6);
        repeat (count) add_instruction();
        mode = $urandom_range(0, 9);
        keep = code_buf.size();
        if (mode == 7)
            keep = $urandom_range(1, code_buf.size());
        if (mode == 8)
            foreach (code_buf[i]) code_buf[i] = 8'($urandom);
        if (mode == 9)
            keep = $urandom_range(0, code_buf.size() - 1);
        send_buffer(keep, mode == 9);
    endtask

    task automatic load_config(input int ph);
        logic [7:0]  params;
        logic        stat;
        logic [15:0] declared;
        case (ph)
            0:
            begin
                params = 8'd0;  stat = 1'b1; declared = 16'd0;
            end
            1:
            begin
                params = 8'hff; stat = 1'b0; declared = 16'hffff;
            end
            2:
            begin
                params = 8'hff; stat = 1'b0; declared = 16'd0;
            end
            default:
            begin
                params   = 8'($urandom);
                stat     = 1'($urandom);
                declared = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
            end
        endcase
        write_reg(CFG_DECLARED_MAX, declared);
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
        write_reg(CFG_PARAM_SLOTS, {8'($urandom), params});
        write_reg(CFG_STATIC_METHOD, {15'($urandom), stat});
        cfg_valid <= 1'b0;
    endtask

    // reset register values: one slot for this, nothing declared
    task automatic test_empty_method();
        code_buf.delete();
        send_buffer(0, 1'b1);
    endtask

    // index operand, then a tableswitch with one pad byte and high below low
    task automatic test_negative_tableswitch();
        code_buf.delete();
        code_buf.push_back(OP_ILOAD);
        code_buf.push_back(8'hff);
        code_buf.push_back(OP_TABLESWITCH);
        code_buf.push_back(8'h00);
        put_word(32'h0000_0010);
        put_word(32'h0000_0005);
        put_word(32'h0000_0003);
        code_buf.push_back(OP_ALOAD_3);
        send_buffer(code_buf.size(), 1'b0);
    endtask

    // six-byte form with the top slot, needed count saturates
    task automatic test_wide_iinc();
        code_buf.delete();
        code_buf.push_back(OP_WIDE);
        code_buf.push_back(OP_IINC);
        code_buf.push_back(8'hff);
        code_buf.push_back(8'hff);
        code_buf.push_back(8'h00);
        code_buf.push_back(8'h01);
        send_buffer(code_buf.size(), 1'b0);
    endtask

    // method ends between the two index bytes of a wide load
    task automatic test_truncated_index();
        code_buf.delete();
        code_buf.push_back(OP_WIDE);
        code_buf.push_back(OP_ILOAD);
        code_buf.push_back(8'h12);
        send_buffer(code_buf.size(), 1'b0);
    endtask

    task automatic test_empty_mid_scan();
        code_buf.delete();
        code_buf.push_back(OP_ISTORE_0 + 8'd2);
        code_buf.push_back(OP_RET);
        send_buffer(code_buf.size(), 1'b1);
    endtask

    task automatic test_random_methods();
        int goal;
        goal = sent_items;
        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            load_config(ph);
            jitter_on = (ph != 3);
            goal += 250;
            while (sent_items < goal)
                random_method();
        end
        jitter_on = 1'b1;
    endtask

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_locals_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_locals_q.pop_front();
                if (result_item.req_slots !== want.req_slots)
                begin
                    $error("req_slots: expected %0d, got %0d",
                           want.req_slots, result_item.req_slots);
                    errors++;
                end
                if (result_item.final_slots !== want.final_slots)
                begin
                    $error("final_slots: expected %0d, got %0d",
                           want.final_slots, result_item.final_slots);
                    errors++;
                end
                if (result_item.corrected !== want.corrected)
                begin
                    $error("corrected: expected %0b, got %0b",
                           want.corrected, result_item.corrected);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL bytecode_local_slot_scanner");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        code_valid   = 1'b0;
        code_item    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        reg_params   = '0;
        reg_static   = 1'b0;
        reg_declared = '0;
        reset_scan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_method();
        test_negative_tableswitch();
        test_wide_iinc();
        test_truncated_index();
        test_empty_mid_scan();
        test_random_methods();
        settle();

        if (errors == 0 && expected_locals_q.size() == 0)
            $display("PASS bytecode_local_slot_scanner");
        else
            $display("FAIL bytecode_local_slot_scanner");
        $finish;
    end

endmodule
